// File: src/olid_pkg.sv
// shared constants, codes and types of the ordered list unit
`default_nettype none

package olid_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int DATA_W     = 32;
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int LEN_W      = $clog2(LIST_DEPTH + 1);

    // command codes
    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_END   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_AFTER = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DUMP      = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd3;

    // the operation that every cell carries out
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    // control broadcast along the chain
    typedef struct packed {
        cell_op_t                  op;
        logic [IDX_W-1:0]          pos;
        logic [IDX_W-1:0]          last_idx;
        logic [LEN_W-1:0]          len;
        logic signed [DATA_W-1:0]  key;
        logic signed [DATA_W-1:0]  value;
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: src/olid_if.sv
// command and response channel interfaces of the ordered list unit
`default_nettype none

interface olid_cmd_if;
    logic                                       valid;
    logic                                       ready;
    logic [olid_pkg::MODE_W-1:0]                mode;
    logic signed [olid_pkg::DATA_W-1:0]         value;
    logic signed [olid_pkg::DATA_W-1:0]         target_value;

    modport source (output valid, output mode, output value, output target_value,
                    input ready);
    modport sink (input valid, input mode, input value, input target_value,
                  output ready);
endinterface

interface olid_rsp_if;
    logic                                       valid;
    logic                                       ready;
    logic [olid_pkg::STATUS_W-1:0]              status;
    logic signed [olid_pkg::DATA_W-1:0]         entry_value;
    logic [olid_pkg::CNT_W-1:0]                 entry_count;
    logic                                       last;

    modport source (output valid, output status, output entry_value, output entry_count,
                    output last, input ready);
    modport sink (input valid, input status, input entry_value, input entry_count,
                  input last, output ready);
endinterface

`default_nettype wire

// File: src/olid_cell.sv
// one list cell: holds one entry, compares it, shifts with its neighbors
`default_nettype none

module olid_cell (
    input  wire logic                               clk,
    input  wire logic [olid_pkg::IDX_W-1:0]         idx,
    input  wire olid_pkg::cell_ctl_t                ctl,
    input  wire logic signed [olid_pkg::DATA_W-1:0] left_data,
    input  wire logic signed [olid_pkg::DATA_W-1:0] right_data,
    input  wire logic signed [olid_pkg::DATA_W-1:0] head_data,
    output logic signed [olid_pkg::DATA_W-1:0]      entry,
    output logic                                    match
);

    logic signed [olid_pkg::DATA_W-1:0] entry_reg;
    logic signed [olid_pkg::DATA_W-1:0] entry_next;
    logic                               occupied;

    assign occupied = olid_pkg::LEN_W'(idx) < ctl.len;
    assign match    = occupied && (entry_reg == ctl.key);
    assign entry    = entry_reg;

    // next entry from the broadcast operation
    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            olid_pkg::CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            olid_pkg::CELL_INSERT:
            begin
                if (idx == ctl.pos)
                    entry_next = ctl.value;
                else if (idx > ctl.pos)
                    entry_next = left_data;
            end
            olid_pkg::CELL_DELETE:
            begin
                if (idx >= ctl.pos)
                    entry_next = right_data;
            end
            olid_pkg::CELL_ROTATE:
            begin
                if (idx == ctl.last_idx)
                    entry_next = head_data;
                else if (idx < ctl.last_idx)
                    entry_next = right_data;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// File: src/ordered_list_insert_delete_unit.sv
// top level of the ordered list unit: command decode, cell chain, response register
//
//  channel | dir | payload                                   | transaction
//  cmd     | in  | mode, value, target_value                 | one command
//  rsp     | out | status, entry_value, entry_count, last    | one result
//
//  insert, delete and unused modes complete on acceptance: all cells compare in
//  parallel and shift in the same cycle; one result follows.
//  dump emits one stored entry per cycle while the response register is free: the chain
//  rotates toward cell 0, which feeds the response register, and is back in
//  order at the end.
//  cmd.ready is low during a dump and while an unread result blocks the
//  response register. reset empties the list; no clearing pass is needed.
`default_nettype none

module ordered_list_insert_delete_unit (
    input  wire logic     clk,
    input  wire logic     rst_n,
    olid_cmd_if.sink      cmd,
    olid_rsp_if.source    rsp
);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t                               state_reg, state_next;
    logic [olid_pkg::LEN_W-1:0]           len_reg, len_next;
    logic [olid_pkg::LEN_W-1:0]           dump_cnt_reg, dump_cnt_next;
    logic                                 out_vld_reg, out_vld_next;
    logic [olid_pkg::STATUS_W-1:0]        out_status_reg, out_status_next;
    logic signed [olid_pkg::DATA_W-1:0]   out_value_reg, out_value_next;
    logic [olid_pkg::CNT_W-1:0]           out_count_reg, out_count_next;
    logic                                 out_last_reg, out_last_next;

    olid_pkg::cell_ctl_t                  ctl;
    logic signed [olid_pkg::DATA_W-1:0]   cell_data [olid_pkg::LIST_DEPTH];
    logic [olid_pkg::LIST_DEPTH-1:0]      cell_match;
    logic                                 any_match;
    logic [olid_pkg::IDX_W-1:0]           match_idx;
    logic                                 slot_free;
    logic                                 accept;
    logic                                 full;
    logic                                 empty;

    // cell chain
    for (genvar i = 0; i < olid_pkg::LIST_DEPTH; i++)
    begin : g_cell
        logic signed [olid_pkg::DATA_W-1:0] left_d;
        logic signed [olid_pkg::DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == olid_pkg::LIST_DEPTH - 1)
        begin : g_end
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        olid_cell u_cell (
            .clk        (clk),
            .idx        (olid_pkg::IDX_W'(i)),
            .ctl        (ctl),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (cell_data[0]),
            .entry      (cell_data[i]),
            .match      (cell_match[i])
        );
    end

    // first matching cell
    always_comb
    begin
        match_idx = '0;
        for (int i = olid_pkg::LIST_DEPTH - 1; i >= 0; i--)
        begin
            if (cell_match[i])
                match_idx = olid_pkg::IDX_W'(i);
        end
    end

    assign any_match = |cell_match;
    assign full      = len_reg == olid_pkg::LEN_W'(olid_pkg::LIST_DEPTH);
    assign empty     = len_reg == '0;
    assign slot_free = !out_vld_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && slot_free;
    assign accept    = cmd.valid && cmd.ready;

    // command decode, dump sequencing and chain control
    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        dump_cnt_next   = dump_cnt_reg;
        out_vld_next    = out_vld_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;

        ctl.op       = olid_pkg::CELL_HOLD;
        ctl.pos      = '0;
        ctl.last_idx = olid_pkg::IDX_W'(len_reg - 1'b1);
        ctl.len      = len_reg;
        ctl.key      = (cmd.mode == olid_pkg::MODE_INS_AFTER) ? cmd.target_value : cmd.value;
        ctl.value    = cmd.value;

        if (accept)
        begin
            out_vld_next    = 1'b1;
            out_value_next  = '0;
            out_last_next   = 1'b1;
            out_status_next = olid_pkg::STATUS_DONE;
            case (cmd.mode)
                olid_pkg::MODE_INS_FRONT, olid_pkg::MODE_INS_END:
                begin
                    if (full)
                        out_status_next = olid_pkg::STATUS_FULL;
                    else
                    begin
                        ctl.op   = olid_pkg::CELL_INSERT;
                        ctl.pos  = (cmd.mode == olid_pkg::MODE_INS_FRONT) ? '0
                                   : olid_pkg::IDX_W'(len_reg);
                        len_next = len_reg + 1'b1;
                    end
                end
                olid_pkg::MODE_INS_AFTER:
                begin
                    if (full)
                        out_status_next = olid_pkg::STATUS_FULL;
                    else if (!any_match)
                        out_status_next = olid_pkg::STATUS_NOTFOUND;
                    else
                    begin
                        ctl.op   = olid_pkg::CELL_INSERT;
                        ctl.pos  = match_idx + 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                end
                olid_pkg::MODE_DELETE:
                begin
                    if (empty)
                        out_status_next = olid_pkg::STATUS_EMPTY;
                    else if (!any_match)
                        out_status_next = olid_pkg::STATUS_NOTFOUND;
                    else
                    begin
                        ctl.op   = olid_pkg::CELL_DELETE;
                        ctl.pos  = match_idx;
                        len_next = len_reg - 1'b1;
                    end
                end
                olid_pkg::MODE_DUMP:
                begin
                    if (empty)
                        out_status_next = olid_pkg::STATUS_EMPTY;
                    else
                    begin
                        out_vld_next  = 1'b0;
                        state_next    = S_DUMP;
                        dump_cnt_next = len_reg;
                    end
                end
                default:
                begin
                    out_status_next = olid_pkg::STATUS_NOTFOUND;
                end
            endcase
            out_count_next = olid_pkg::CNT_W'(len_next);
        end
        else if (state_reg == S_DUMP && slot_free)
        begin
            // emit head entry and rotate the stored part of the chain
            ctl.op          = olid_pkg::CELL_ROTATE;
            out_vld_next    = 1'b1;
            out_status_next = olid_pkg::STATUS_DONE;
            out_value_next  = cell_data[0];
            out_count_next  = olid_pkg::CNT_W'(len_reg);
            out_last_next   = dump_cnt_reg == olid_pkg::LEN_W'(1);
            dump_cnt_next   = dump_cnt_reg - 1'b1;
            if (dump_cnt_reg == olid_pkg::LEN_W'(1))
                state_next = S_IDLE;
        end
    end

    // state, list length and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            len_reg        <= '0;
            dump_cnt_reg   <= '0;
            out_vld_reg    <= 1'b0;
            out_status_reg <= '0;
            out_value_reg  <= '0;
            out_count_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            dump_cnt_reg   <= dump_cnt_next;
            out_vld_reg    <= out_vld_next;
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
            out_count_reg  <= out_count_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_value = out_value_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.last        = out_last_reg;

endmodule

`default_nettype wire

// File: bench/ordered_list_insert_delete_unit_tb.sv
// self-checking testbench of the ordered list unit with a shadow list predictor
`timescale 1ns / 1ps

module ordered_list_insert_delete_unit_tb;

    import olid_pkg::*;

    // spare command codes, answered with not found
    localparam logic [MODE_W-1:0] MODE_FIRST_SPARE = 3'd5;
    localparam logic [MODE_W-1:0] MODE_LAST_SPARE  = 3'd7;

    localparam int CLK_HALF       = 10;
    localparam int MAX_GAP        = 18;
    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 20;
    localparam int POOL_SIZE      = 12;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [DATA_W-1:0]  value;
        logic signed [DATA_W-1:0]  target;
    } list_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [DATA_W-1:0]  entry_value;
        logic [CNT_W-1:0]          entry_count;
        logic                      last;
    } list_rsp_t;

    logic clk;
    logic rst_n;

    olid_cmd_if cmd_bus ();
    olid_rsp_if rsp_bus ();

    ordered_list_insert_delete_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    // shadow copy of the list
    logic signed [DATA_W-1:0] list_shadow [LIST_DEPTH];
    int shadow_len;

    list_cmd_t cmd_queue [$];
    list_rsp_t due_results [$];
    logic signed [DATA_W-1:0] value_pool [POOL_SIZE];

    bit cmd_fire;
    bit no_idle;
    int long_hold_req;
    int long_hold_seen;
    int send_gap;
    int recv_hold;
    int stall_cycles;
    int fail_count;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // first entry equal to key, or -1
    function automatic int find_entry(logic signed [DATA_W-1:0] key);
        int i;
        for (i = 0; i < shadow_len; i++)
        begin
            if (list_shadow[i] == key)
                return i;
        end
        return -1;
    endfunction

    function automatic void expect_result(logic [STATUS_W-1:0] status,
                                          logic signed [DATA_W-1:0] val, logic last);
        list_rsp_t r;
        r.status      = status;
        r.entry_value = val;
        r.entry_count = CNT_W'(shadow_len);
        r.last        = last;
        due_results.push_back(r);
    endfunction

    // update the shadow list and queue the results of one command
    function automatic void apply_list_command(list_cmd_t c);
        int pos;
        int i;
        case (c.mode)
            MODE_INS_FRONT, MODE_INS_END, MODE_INS_AFTER:
            begin
                if (shadow_len >= LIST_DEPTH)
                    expect_result(STATUS_FULL, '0, 1'b1);
                else
                begin
                    if (c.mode == MODE_INS_FRONT)
                        pos = 0;
                    else if (c.mode == MODE_INS_END)
                        pos = shadow_len;
                    else
                    begin
                        pos = find_entry(c.target);
                        if (pos >= 0)
                            pos = pos + 1;
                    end
                    if (pos < 0)
                        expect_result(STATUS_NOTFOUND, '0, 1'b1);
                    else
                    begin
                        for (i = shadow_len; i > pos; i--)
                            list_shadow[i] = list_shadow[i-1];
                        list_shadow[pos] = c.value;
                        shadow_len++;
                        expect_result(STATUS_DONE, '0, 1'b1);
                    end
                end
            end
            MODE_DELETE:
            begin
                pos = find_entry(c.value);
                if (shadow_len == 0)
                    expect_result(STATUS_EMPTY, '0, 1'b1);
                else if (pos < 0)
                    expect_result(STATUS_NOTFOUND, '0, 1'b1);
                else
                begin
                    for (i = pos; i + 1 < shadow_len; i++)
                        list_shadow[i] = list_shadow[i+1];
                    shadow_len--;
                    expect_result(STATUS_DONE, '0, 1'b1);
                end
            end
            MODE_DUMP:
            begin
                if (shadow_len == 0)
                    expect_result(STATUS_EMPTY, '0, 1'b1);
                else
                begin
                    for (i = 0; i < shadow_len; i++)
                        expect_result(STATUS_DONE, list_shadow[i], i == shadow_len - 1);
                end
            end
            default:
                expect_result(STATUS_NOTFOUND, '0, 1'b1);
        endcase
    endfunction

    function automatic void report_failure(string what, list_rsp_t exp, list_rsp_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $write("%0t %s: exp status %0d value %0d count %0d last %0d, ",
                   $time, what, exp.status, exp.entry_value, exp.entry_count, exp.last);
            $display("got status %0d value %0d count %0d last %0d",
                     got.status, got.entry_value, got.entry_count, got.last);
        end
    endfunction

    // monitor: check results, then predict for the accepted command
    always @(posedge clk)
    begin
        list_rsp_t got;
        list_cmd_t c;
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got.status      = rsp_bus.status;
                got.entry_value = rsp_bus.entry_value;
                got.entry_count = rsp_bus.entry_count;
                got.last        = rsp_bus.last;
                if (due_results.size() == 0)
                    report_failure("unexpected result", '0, got);
                else if (got !== due_results[0])
                    report_failure("mismatch", due_results.pop_front(), got);
                else
                    void'(due_results.pop_front());
            end
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                c.mode   = cmd_bus.mode;
                c.value  = cmd_bus.value;
                c.target = cmd_bus.target_value;
                apply_list_command(c);
            end
            if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            cmd_fire <= cmd_bus.valid && cmd_bus.ready;
        end
    end

    // command driver, fed from cmd_queue
    always @(negedge clk)
    begin
        list_cmd_t c;
        if (!rst_n)
            cmd_bus.valid <= 1'b0;
        else if (!cmd_bus.valid || cmd_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                cmd_bus.valid <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(1, MAX_GAP) - 1;
                cmd_bus.valid <= 1'b0;
            end
            else if (cmd_queue.size() > 0)
            begin
                c = cmd_queue.pop_front();
                cmd_bus.valid        <= 1'b1;
                cmd_bus.mode         <= c.mode;
                cmd_bus.value        <= c.value;
                cmd_bus.target_value <= c.target;
            end
            else
                cmd_bus.valid <= 1'b0;
        end
    end

    // result receiver with random stalls and one long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else if (recv_hold > 0)
        begin
            recv_hold--;
            rsp_bus.ready <= 1'b0;
        end
        else if (long_hold_req != long_hold_seen)
        begin
            long_hold_seen = long_hold_req;
            recv_hold = LONG_HOLD - 1;
            rsp_bus.ready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            recv_hold = $urandom_range(1, MAX_GAP) - 1;
            rsp_bus.ready <= 1'b0;
        end
        else
            rsp_bus.ready <= 1'b1;
    end

    // watchdog on cycles without any transaction
    initial
    begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    function automatic void queue_cmd(logic [MODE_W-1:0] m, logic signed [DATA_W-1:0] v,
                                      logic signed [DATA_W-1:0] t);
        list_cmd_t c;
        c.mode   = m;
        c.value  = v;
        c.target = t;
        cmd_queue.push_back(c);
    endfunction

    // mostly values from a small pool so that searches hit
    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic void queue_random(int count, int ins_pct, int del_pct);
        int n;
        int r;
        logic [MODE_W-1:0] m;
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < ins_pct)
                m = MODE_W'($urandom_range(MODE_INS_FRONT, MODE_INS_AFTER));
            else if (r < ins_pct + del_pct)
                m = MODE_DELETE;
            else if (r < 97)
                m = MODE_DUMP;
            else
                m = MODE_W'($urandom_range(MODE_FIRST_SPARE, MODE_LAST_SPARE));
            queue_cmd(m, pick_value(), pick_value());
        end
    endfunction

    task automatic wait_for_drain();
        while (cmd_queue.size() != 0 || cmd_bus.valid || due_results.size() != 0)
            @(posedge clk);
    endtask

    // stimulus and end of run
    initial
    begin
        int i;
        cmd_bus.valid        = 1'b0;
        cmd_bus.mode         = '0;
        cmd_bus.value        = '0;
        cmd_bus.target_value = '0;
        rsp_bus.ready        = 1'b0;
        cmd_fire       = 1'b0;
        no_idle        = 1'b0;
        long_hold_req  = 0;
        long_hold_seen = 0;
        send_gap       = 0;
        recv_hold      = 0;
        stall_cycles   = 0;
        fail_count     = 0;
        shadow_len     = 0;
        for (i = 0; i < LIST_DEPTH; i++)
            list_shadow[i] = '0;

        value_pool[0] = 32'sh7FFF_FFFF;
        value_pool[1] = 32'sh8000_0000;
        value_pool[2] = 32'sh0000_0000;
        value_pool[3] = -32'sd1;
        value_pool[4] = 32'sh0000_0001;
        value_pool[5] = 32'sh5555_5555;
        value_pool[6] = 32'shAAAA_AAAA;
        for (i = 7; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list cases, spare codes, extremes, first match, dumps
        queue_cmd(MODE_DUMP, 0, 0);
        queue_cmd(MODE_DELETE, 5, 0);
        queue_cmd(MODE_INS_AFTER, 9, 0);
        for (i = MODE_FIRST_SPARE; i <= MODE_LAST_SPARE; i++)
            queue_cmd(MODE_W'(i), $urandom, $urandom);
        queue_cmd(MODE_INS_FRONT, 32'sh7FFF_FFFF, 0);
        queue_cmd(MODE_INS_FRONT, 32'sh8000_0000, 0);
        queue_cmd(MODE_INS_END, 0, 32'sh7FFF_FFFF);
        queue_cmd(MODE_INS_END, -1, 0);
        queue_cmd(MODE_INS_AFTER, 32'sh5555_5555, 32'sh8000_0000);
        queue_cmd(MODE_INS_AFTER, 32'shAAAA_AAAA, -1);
        queue_cmd(MODE_INS_AFTER, 1, 32'sh0001_2345);
        queue_cmd(MODE_INS_FRONT, 32'sh7FFF_FFFF, 0);
        queue_cmd(MODE_DUMP, 0, 0);
        queue_cmd(MODE_DELETE, 32'sh7FFF_FFFF, 0);
        queue_cmd(MODE_DELETE, 32'sh0000_1234, 0);
        queue_cmd(MODE_DELETE, 32'shAAAA_AAAA, 0);
        queue_cmd(MODE_INS_AFTER, 3, 32'sh7FFF_FFFF);
        queue_cmd(MODE_DUMP, 0, 0);
        wait_for_drain();

        // fill to the limit, hit the full list with every insert, dump all
        for (i = shadow_len; i < LIST_DEPTH; i++)
            queue_cmd(MODE_W'($urandom_range(MODE_INS_FRONT, MODE_INS_END)), pick_value(), 0);
        queue_cmd(MODE_INS_FRONT, $urandom, 0);
        queue_cmd(MODE_INS_END, $urandom, 0);
        queue_cmd(MODE_INS_AFTER, $urandom, value_pool[0]);
        queue_cmd(MODE_DUMP, 0, 0);
        wait_for_drain();

        // mostly deletes, toward an empty list
        queue_random(20, 20, 65);
        wait_for_drain();

        // receiver holds off while commands keep coming
        long_hold_req++;
        queue_random(20, 70, 20);
        wait_for_drain();

        queue_random(20, 45, 40);
        wait_for_drain();

        // closing stretch without idling
        no_idle = 1'b1;
        queue_random(20, 45, 40);
        wait_for_drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        while (due_results.size() != 0)
            report_failure("missing result", due_results.pop_front(), '0);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
src/olid_pkg.sv
src/olid_if.sv
src/olid_cell.sv
src/ordered_list_insert_delete_unit.sv
bench/ordered_list_insert_delete_unit_tb.sv
